// File: sv/psurc_pkg.sv
// Shared types and constants for the PSU reply checker and LINEAR11 decoder.
// Holds the input item type, status codes, decode kinds and the register map.
// No dependencies.
`default_nettype none

package psurc_pkg;

  localparam logic [7:0] NAK_BYTE = 8'hFE;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ECHO     = 2'd1;
  localparam logic [1:0] ST_NAK      = 2'd2;
  localparam logic [1:0] ST_UNSUPP   = 2'd3;

  localparam int unsigned VALUE_W = 46;

  localparam logic [19:0] SCALE_MILLI = 20'd1000;
  localparam logic [19:0] SCALE_CENTI = 20'd100;
  localparam logic [19:0] SCALE_MICRO = 20'd1000000;
  localparam logic [19:0] SCALE_UNIT  = 20'd1;

  localparam logic [7:0] RAIL_SINGLE = 8'd1;
  localparam logic [7:0] RAIL_MULTI  = 8'd2;

  typedef enum logic [2:0] {
    KIND_MILLI,
    KIND_CENTI,
    KIND_MICRO,
    KIND_FAN,
    KIND_RAW,
    KIND_RAIL,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    logic [7:0] req_command;
    logic [7:0] req_register;
    logic [7:0] req_third;
    logic [7:0] reply_echo_cmd;
    logic [7:0] reply_echo_reg;
    logic [7:0] reply_data0;
    logic [7:0] reply_data1;
    logic [7:0] reply_data2;
    logic [7:0] reply_data3;
  } item_t;

  function automatic kind_t reg_kind(input logic [7:0] addr);
    kind_t k;
    unique case (addr)
      8'h20, 8'h24, 8'h25, 8'h26,
      8'h27, 8'h28, 8'h29, 8'h30: k = KIND_MILLI;
      8'h2B:                      k = KIND_CENTI;
      8'h2A:                      k = KIND_MICRO;
      8'h40:                      k = KIND_FAN;
      8'h12, 8'h41, 8'h42,
      8'hD0, 8'hD1:               k = KIND_RAW;
      8'hC0:                      k = KIND_RAIL;
      default:                    k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: sv/psu_reply_check_and_linear11_decode_core.sv
// PSU reply checker and LINEAR11 decoder. Each input transaction carries a
// request and the first six reply bytes; one result transaction follows with a
// status and a 46-bit two's complement value (zero on any error). The block
// takes one transaction per cycle while the output side does not stall: an
// input register feeds the check and decode logic, whose result lands in an
// output register. Both registers hold under back-pressure, and input is
// still taken while a result waits as long as the input register is empty.
`default_nettype none

module psu_reply_check_and_linear11_decode_core
  import psurc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            req_command,
  input  wire logic [7:0]            req_register,
  input  wire logic [7:0]            req_third,
  input  wire logic [7:0]            reply_echo_cmd,
  input  wire logic [7:0]            reply_echo_reg,
  input  wire logic [7:0]            reply_data0,
  input  wire logic [7:0]            reply_data1,
  input  wire logic [7:0]            reply_data2,
  input  wire logic [7:0]            reply_data3,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 status,
  output logic signed [VALUE_W-1:0]  value
);

  item_t                      item;
  logic                       item_valid;
  logic                       out_free;
  logic                       item_move;
  logic [1:0]                 dec_status;
  logic signed [VALUE_W-1:0]  dec_value;

  assign out_free  = !out_valid || out_ready;
  assign item_move = item_valid && out_free;
  assign in_ready  = !item_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{req_command, req_register, req_third, reply_echo_cmd,
                reply_echo_reg, reply_data0, reply_data1, reply_data2, reply_data3};
    end
  end

  psurc_decode u_decode (
    .item   (item),
    .status (dec_status),
    .value  (dec_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      status <= dec_status;
      value  <= dec_value;
    end
  end

  // Error results always carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (value == '0))
    else $error("nonzero value on an error result");

  // A held item with a stalled output must block the input side.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    item_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline is full");

  // A stalled item stays in the input register.
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_move |=> item_valid && $stable(item))
    else $error("held item lost or changed");

  // A moving item always produces a result in the next cycle.
  a_item_to_out: assert property (@(posedge clk) disable iff (rst)
    item_move |=> out_valid)
    else $error("item moved without producing a result");

endmodule

`default_nettype wire

// File: sv/psurc_lin11.sv
// LINEAR11 word decoder: constant-scaled mantissa shifted by the exponent.
// Depends on psurc_pkg for the value width.
`default_nettype none

module psurc_lin11
  import psurc_pkg::*;
(
  input  wire logic [15:0]               word,
  input  wire logic [19:0]               scale,
  input  wire logic                      mant_sgn,
  output logic signed [VALUE_W-1:0]      result
);

  logic [4:0]         expo;
  logic [4:0]         rshift;
  logic signed [11:0] mant;
  logic signed [32:0] prod;
  logic signed [46:0] wide;
  logic signed [46:0] shifted;

  assign expo   = word[15:11];
  assign mant   = mant_sgn ? $signed({word[10], word[10:0]}) : $signed({1'b0, word[10:0]});
  assign prod   = mant * $signed({1'b0, scale});
  assign wide   = {{14{prod[32]}}, prod};
  // A negative exponent e (16..31 as raw bits) is a right shift by 32 - e.
  assign rshift = 5'd0 - expo;

  always_comb begin
    if (!expo[4]) begin
      shifted = wide <<< expo[3:0];
    end else begin
      shifted = wide >>> rshift;
    end
  end

  assign result = shifted[VALUE_W-1:0];

endmodule

`default_nettype wire

// File: sv/psurc_decode.sv
// Reply checks (echo, NAK) and per-register decode of one registered item.
// Depends on psurc_pkg and psurc_lin11.
`default_nettype none

module psurc_decode
  import psurc_pkg::*;
(
  input  wire item_t                     item,
  output logic [1:0]                     status,
  output logic signed [VALUE_W-1:0]      value
);

  kind_t                      kind;
  logic [19:0]                scale;
  logic                       mant_sgn;
  logic signed [VALUE_W-1:0]  lin_value;
  logic                       echo_bad;
  logic                       nak_seen;

  assign kind     = reg_kind(item.req_register);
  assign echo_bad = (item.reply_echo_cmd != item.req_command) ||
                    (item.reply_echo_reg != item.req_register);
  // A third request byte equal to the NAK code masks the NAK test.
  assign nak_seen = (item.req_third != NAK_BYTE) && (item.reply_data0 == NAK_BYTE);

  always_comb begin
    unique case (kind)
      KIND_CENTI: scale = SCALE_CENTI;
      KIND_MICRO: scale = SCALE_MICRO;
      KIND_FAN:   scale = SCALE_UNIT;
      default:    scale = SCALE_MILLI;
    endcase
    mant_sgn = (kind != KIND_FAN);
  end

  psurc_lin11 u_lin11 (
    .word      ({item.reply_data1, item.reply_data0}),
    .scale     (scale),
    .mant_sgn  (mant_sgn),
    .result    (lin_value)
  );

  always_comb begin
    status = ST_OK;
    value  = '0;
    priority if (echo_bad) begin
      status = ST_ECHO;
    end else if (nak_seen) begin
      status = ST_NAK;
    end else begin
      unique case (kind)
        KIND_MILLI, KIND_CENTI, KIND_MICRO, KIND_FAN: begin
          value = lin_value;
        end
        KIND_RAW: begin
          value = $signed({14'd0, item.reply_data3, item.reply_data2,
                           item.reply_data1, item.reply_data0});
        end
        KIND_RAIL: begin
          priority if (item.reply_data0 == RAIL_SINGLE) begin
            value = '0;
          end else if (item.reply_data0 == RAIL_MULTI) begin
            value = VALUE_W'(1);
          end else begin
            value = VALUE_W'(255);
          end
        end
        default: begin
          status = ST_UNSUPP;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the PSU reply checker and LINEAR11 decoder core.
// Depends on psurc_pkg and psu_reply_check_and_linear11_decode_core; a small
// scoreboard class decodes each accepted request and checks the replies in order.
`timescale 1ns / 1ps

module testbench;
  import psurc_pkg::*;

  localparam logic [7:0] CMD_READ  = 8'h51;
  localparam logic [7:0] CMD_WRITE = 8'h50;

  localparam logic [7:0] REG_VOLT_IN    = 8'h20;
  localparam logic [7:0] REG_VOLT_12V   = 8'h24;
  localparam logic [7:0] REG_VOLT_5V    = 8'h25;
  localparam logic [7:0] REG_VOLT_3V3   = 8'h26;
  localparam logic [7:0] REG_CURR_12V   = 8'h27;
  localparam logic [7:0] REG_CURR_5V    = 8'h28;
  localparam logic [7:0] REG_CURR_3V3   = 8'h29;
  localparam logic [7:0] REG_TEMP       = 8'h30;
  localparam logic [7:0] REG_POWER      = 8'h2A;
  localparam logic [7:0] REG_EFFICIENCY = 8'h2B;
  localparam logic [7:0] REG_FAN_SPEED  = 8'h40;
  localparam logic [7:0] REG_REVISION   = 8'h12;
  localparam logic [7:0] REG_UPTIME     = 8'h41;
  localparam logic [7:0] REG_UPTIME_ALL = 8'h42;
  localparam logic [7:0] REG_FAN_CFG_A  = 8'hD0;
  localparam logic [7:0] REG_FAN_CFG_B  = 8'hD1;
  localparam logic [7:0] REG_MULTIRAIL  = 8'hC0;
  localparam logic [7:0] REG_UNKNOWN    = 8'h00;

  localparam logic [45:0] RAIL_UNKNOWN_CODE = 46'd255;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [1:0]  status;
    logic [45:0] value;
  } decode_t;

  class reply_scoreboard;
    decode_t     awaited[$];
    int unsigned errors = 0;
    int unsigned seen = 0;
    int unsigned per_status[4] = '{0, 0, 0, 0};

    function logic signed [63:0] lin11(logic [15:0] word, logic [19:0] scale, bit sgn);
      logic [4:0]          ex;
      logic signed [63:0]  mant;
      logic signed [63:0]  prod;
      int unsigned         sh;
      ex = word[15:11];
      if (sgn) begin
        mant = {{53{word[10]}}, word[10:0]};
      end else begin
        mant = {53'd0, word[10:0]};
      end
      prod = mant * $signed({44'd0, scale});
      if (!ex[4]) begin
        prod = prod <<< ex;
      end else begin
        // Negative exponent: arithmetic shift rounds toward minus infinity.
        sh = 32 - int'(ex);
        prod = prod >>> sh;
      end
      return prod;
    endfunction

    function decode_t decode_reply(item_t it);
      decode_t            d;
      logic [15:0]        word;
      logic signed [63:0] wide;
      d.status = ST_OK;
      d.value  = '0;
      wide     = '0;
      word     = {it.reply_data1, it.reply_data0};
      if (it.reply_echo_cmd != it.req_command || it.reply_echo_reg != it.req_register) begin
        d.status = ST_ECHO;
      end else if (it.req_third != NAK_BYTE && it.reply_data0 == NAK_BYTE) begin
        d.status = ST_NAK;
      end else begin
        case (it.req_register)
          REG_VOLT_IN, REG_VOLT_12V, REG_VOLT_5V, REG_VOLT_3V3,
          REG_CURR_12V, REG_CURR_5V, REG_CURR_3V3, REG_TEMP: begin
            wide = lin11(word, SCALE_MILLI, 1'b1);
            d.value = wide[45:0];
          end
          REG_EFFICIENCY: begin
            wide = lin11(word, SCALE_CENTI, 1'b1);
            d.value = wide[45:0];
          end
          REG_POWER: begin
            wide = lin11(word, SCALE_MICRO, 1'b1);
            d.value = wide[45:0];
          end
          REG_FAN_SPEED: begin
            wide = lin11(word, SCALE_UNIT, 1'b0);
            d.value = wide[45:0];
          end
          REG_REVISION, REG_UPTIME, REG_UPTIME_ALL, REG_FAN_CFG_A, REG_FAN_CFG_B: begin
            d.value = {14'd0, it.reply_data3, it.reply_data2, word};
          end
          REG_MULTIRAIL: begin
            if (it.reply_data0 == RAIL_SINGLE) begin
              d.value = 46'd0;
            end else if (it.reply_data0 == RAIL_MULTI) begin
              d.value = 46'd1;
            end else begin
              d.value = RAIL_UNKNOWN_CODE;
            end
          end
          default: begin
            d.status = ST_UNSUPP;
          end
        endcase
      end
      return d;
    endfunction

    function void note(item_t it);
      awaited.push_back(decode_reply(it));
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void check(logic [1:0] st, logic [45:0] v);
      decode_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected reply: status %0d value %0d", st, $signed(v));
        end
        return;
      end
      want = awaited.pop_front();
      seen++;
      per_status[want.status]++;
      if (st !== want.status || v !== want.value) begin
        errors++;
        if (errors <= 10) begin
          $display("reply %0d wrong: status %0d value %0d, wanted status %0d value %0d",
                   seen, st, $signed(v), want.status, $signed(want.value));
        end
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                req_command = '0;
  logic [7:0]                req_register = '0;
  logic [7:0]                req_third = '0;
  logic [7:0]                reply_echo_cmd = '0;
  logic [7:0]                reply_echo_reg = '0;
  logic [7:0]                reply_data0 = '0;
  logic [7:0]                reply_data1 = '0;
  logic [7:0]                reply_data2 = '0;
  logic [7:0]                reply_data3 = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] value;

  reply_scoreboard scb;
  int unsigned     sent = 0;
  int              src_stretch = 0;
  int              sink_stretch = 0;
  int              sink_wait = 0;
  int              idle_cycles = 0;

  psu_reply_check_and_linear11_decode_core i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Either side draws a random wait for each transaction, with occasional stretches
  // of back-to-back traffic.
  function automatic int draw_wait(inout int stretch);
    if (stretch > 0) begin
      stretch--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      stretch = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic item_t mk(logic [7:0] cmd, logic [7:0] addr, logic [7:0] third,
                               logic [7:0] ecmd, logic [7:0] ereg, logic [7:0] d0,
                               logic [7:0] d1, logic [7:0] d2, logic [7:0] d3);
    return '{cmd, addr, third, ecmd, ereg, d0, d1, d2, d3};
  endfunction

  function automatic logic [7:0] supported_register(int idx);
    case (idx)
      0:       return REG_VOLT_IN;
      1:       return REG_VOLT_12V;
      2:       return REG_VOLT_5V;
      3:       return REG_VOLT_3V3;
      4:       return REG_CURR_12V;
      5:       return REG_CURR_5V;
      6:       return REG_CURR_3V3;
      7:       return REG_TEMP;
      8:       return REG_POWER;
      9:       return REG_EFFICIENCY;
      10:      return REG_FAN_SPEED;
      11:      return REG_REVISION;
      12:      return REG_UPTIME;
      13:      return REG_UPTIME_ALL;
      14:      return REG_FAN_CFG_A;
      15:      return REG_FAN_CFG_B;
      default: return REG_MULTIRAIL;
    endcase
  endfunction

  // Mostly well-formed replies with random data; some with a corrupted echo,
  // the rest pure noise.
  function automatic item_t make_random_item();
    item_t       it;
    logic [95:0] raw;
    int          pick;
    raw  = {$urandom, $urandom, $urandom};
    it   = raw[71:0];
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      it.req_command  = ($urandom_range(0, 4) == 0) ? CMD_WRITE : CMD_READ;
      it.req_register = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                    : supported_register($urandom_range(0, 16));
      case ($urandom_range(0, 5))
        0:       it.req_third = NAK_BYTE;
        1:       it.req_third = 8'($urandom);
        default: it.req_third = 8'h00;
      endcase
      it.reply_echo_cmd = it.req_command;
      it.reply_echo_reg = it.req_register;
      if ($urandom_range(0, 9) == 0) begin
        it.reply_data0 = NAK_BYTE;
      end else if (it.req_register == REG_MULTIRAIL && $urandom_range(0, 1) == 1) begin
        it.reply_data0 = 8'($urandom_range(1, 2));
      end
      if (pick >= 70) begin
        if ($urandom_range(0, 1) == 1) begin
          it.reply_echo_cmd ^= 8'($urandom_range(1, 255));
        end else begin
          it.reply_echo_reg ^= 8'($urandom_range(1, 255));
        end
      end
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = draw_wait(src_stretch);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_command    <= it.req_command;
    req_register   <= it.req_register;
    req_third      <= it.req_third;
    reply_echo_cmd <= it.reply_echo_cmd;
    reply_echo_reg <= it.reply_echo_reg;
    reply_data0    <= it.reply_data0;
    reply_data1    <= it.reply_data1;
    reply_data2    <= it.reply_data2;
    reply_data3    <= it.reply_data3;
    do @(posedge clk); while (!in_ready);
    scb.note(it);
    sent++;
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    while (scb.outstanding() != 0) @(posedge clk);
  endtask

  // Result side: check on each accepted transaction, then draw a stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        scb.check(status, value);
        sink_wait = draw_wait(sink_stretch);
        if (sink_wait > 0) begin
          out_ready <= 1'b0;
        end
      end else if (!out_ready) begin
        if (sink_wait > 0) begin
          sink_wait--;
        end
        if (sink_wait == 0) begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("No transaction for %0d cycles; giving up.", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    scb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Exponent and mantissa extremes for each scaling.
    send_item(mk(CMD_READ, REG_VOLT_IN, 8'h00, CMD_READ, REG_VOLT_IN, 8'hFF, 8'h7B, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_VOLT_IN, 8'h00, CMD_READ, REG_VOLT_IN, 8'h00, 8'h7C, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_POWER, 8'h00, CMD_READ, REG_POWER, 8'hFF, 8'h7B, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_POWER, 8'h00, CMD_READ, REG_POWER, 8'h00, 8'h7C, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_EFFICIENCY, 8'h00, CMD_READ, REG_EFFICIENCY,
                 8'hFF, 8'h87, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_TEMP, 8'h00, CMD_READ, REG_TEMP, 8'hFD, 8'hFF, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_FAN_SPEED, 8'h00, CMD_READ, REG_FAN_SPEED,
                 8'hFF, 8'h7F, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_FAN_SPEED, 8'h00, CMD_READ, REG_FAN_SPEED,
                 8'hFF, 8'h87, 8'h00, 8'h00));
    // Raw 32-bit registers.
    send_item(mk(CMD_READ, REG_REVISION, 8'h00, CMD_READ, REG_REVISION,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(mk(CMD_READ, REG_UPTIME, 8'h00, CMD_READ, REG_UPTIME, 8'h01, 8'h02, 8'h03, 8'h84));
    // Multirail mapping.
    send_item(mk(CMD_READ, REG_MULTIRAIL, 8'h00, CMD_READ, REG_MULTIRAIL,
                 RAIL_SINGLE, 8'h00, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_MULTIRAIL, 8'h00, CMD_READ, REG_MULTIRAIL,
                 RAIL_MULTI, 8'h00, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_MULTIRAIL, 8'h00, CMD_READ, REG_MULTIRAIL,
                 8'h00, 8'hFF, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_MULTIRAIL, NAK_BYTE, CMD_READ, REG_MULTIRAIL,
                 NAK_BYTE, 8'h00, 8'h00, 8'h00));
    // Echo faults, which take precedence over a NAK.
    send_item(mk(CMD_READ, REG_VOLT_IN, 8'h00, CMD_WRITE, REG_VOLT_IN, 8'h10, 8'h00, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_VOLT_IN, 8'h00, CMD_READ, REG_TEMP, 8'h10, 8'h00, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_TEMP, 8'h00, CMD_READ, REG_POWER, NAK_BYTE, 8'h00, 8'h00, 8'h00));
    // NAK, NAK masked by the third request byte, NAK ahead of an unknown register.
    send_item(mk(CMD_READ, REG_CURR_5V, 8'h00, CMD_READ, REG_CURR_5V,
                 NAK_BYTE, 8'h12, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_VOLT_IN, NAK_BYTE, CMD_READ, REG_VOLT_IN,
                 NAK_BYTE, 8'hF3, 8'h00, 8'h00));
    send_item(mk(CMD_READ, REG_UNKNOWN, 8'h00, CMD_READ, REG_UNKNOWN,
                 NAK_BYTE, 8'h00, 8'h00, 8'h00));
    // Unknown registers and write commands.
    send_item(mk(CMD_READ, 8'hFF, 8'h00, CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(mk(CMD_WRITE, 8'h21, 8'hFF, CMD_WRITE, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(mk(CMD_WRITE, REG_VOLT_12V, 8'h00, CMD_WRITE, REG_VOLT_12V,
                 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(mk(8'h00, REG_UNKNOWN, 8'h00, 8'h00, REG_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00));

    drain_pause();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        drain_pause();
      end
      send_item(make_random_item());
    end
    in_valid <= 1'b0;
    while (scb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests, checked %0d replies: %0d decoded, %0d echo faults,",
             sent, scb.seen, scb.per_status[ST_OK], scb.per_status[ST_ECHO]);
    $display("%0d NAKs, %0d unknown registers; %0d errors.",
             scb.per_status[ST_NAK], scb.per_status[ST_UNSUPP], scb.errors);
    if (scb.errors == 0 && scb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: psu_reply_check_and_linear11_decode_core.f
sv/psurc_pkg.sv
sv/psurc_lin11.sv
sv/psurc_decode.sv
sv/psu_reply_check_and_linear11_decode_core.sv
bench/testbench.sv
